[design/lz4d_pkg.sv]
// Package: shared types and codes of the LZ4 block decoder.
package lz4d_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TOKEN,
    PH_LITLEN,
    PH_LIT,
    PH_OFFLO,
    PH_OFFHI,
    PH_MLEN,
    PH_COPY
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TRUNC    = 3'd1,
    ST_OVER     = 3'd2,
    ST_OFFSET   = 3'd3,
    ST_MISMATCH = 3'd4,
    ST_REJECT   = 3'd5
  } status_t;

  typedef enum logic {
    FN_DATA = 1'b0,
    FN_TICK = 1'b1
  } func_t;

  localparam int unsigned BLOCK_SIZE_W = 23;
  localparam logic [3:0]  NIBBLE_EXT   = 4'd15;
  localparam logic [7:0]  BYTE_EXT     = 8'd255;
  localparam int unsigned MIN_MATCH    = 4;

  typedef struct packed {
    logic    byte_valid;
    logic    is_copy;
    logic    write;
    logic    fwd;
    logic    copy_pending;
    logic    block_done;
    status_t status;
  } stage_ctl_t;

endpackage

[design/lz4d_if.sv]
// Interfaces: compressed input channel and decoded output channel.
interface lz4d_in_if;
  logic                                valid;
  logic                                ready;
  lz4d_pkg::func_t                     func;
  logic [7:0]                          data_byte;
  logic                                last_byte;
  logic [lz4d_pkg::BLOCK_SIZE_W-1:0]   block_size;

  modport source (output valid, func, data_byte, last_byte, block_size, input ready);
  modport sink   (input valid, func, data_byte, last_byte, block_size, output ready);
endinterface

interface lz4d_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  logic                byte_valid;
  logic                copy_pending;
  logic                block_done;
  lz4d_pkg::status_t   status;

  modport source (output valid, out_byte, byte_valid, copy_pending, block_done, status,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, copy_pending, block_done, status,
                  output ready);
endinterface

[design/lz4_block_decoder_top.sv]
// Top level: LZ4 block decoder with history memory, parse stage and output register.
//
//  channel | dir | payload
//  --------+-----+--------------------------------------------------------
//  din     | in  | func, data_byte, last_byte, block_size
//  dout    | out | out_byte, byte_valid, copy_pending, block_done, status
//
//  One item per cycle unless dout stalls: parsing decides at accept, the history read
//  issues at the same edge and the byte is resolved in the result stage, then sits in
//  the output register, which drives dout.valid.
//  A copy byte that reads the entry written by the item just ahead is forwarded.
//  Synchronous reset clears control state; history is not cleared.
//  din.ready falls only when the result stage and the output register both hold
//  items and dout.ready is low.
module lz4_block_decoder_top #(
  parameter int unsigned WINDOW_BYTES    = 65536,
  parameter int unsigned MAX_BLOCK_BYTES = 4194304
) (
  input  logic              clk,
  input  logic              rst,
  lz4d_in_if.sink           din,
  lz4d_out_if.source        dout
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned CW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned LW = CW + 2;
  localparam logic [AW:0]   WIN_EXT  = (AW + 1)'(WINDOW_BYTES);
  localparam logic [AW-1:0] WIN_LAST = AW'(WINDOW_BYTES - 1);

  // parse state
  lz4d_pkg::phase_t  phase, phase_next;
  logic [3:0]        match_nibble, match_nibble_next;
  logic [CW-1:0]     lit_left, lit_left_next;
  logic [CW-1:0]     match_left, match_left_next;
  logic [15:0]       match_dist, match_dist_next;
  logic [CW-1:0]     produced, produced_next;
  logic [CW-1:0]     expected, expected_next;
  lz4d_pkg::status_t error_code, error_code_next;
  logic              ends_after_copy, ends_after_copy_next;
  logic [AW-1:0]     wptr, wptr_next;

  // history
  logic [7:0]        hist [WINDOW_BYTES];
  logic [7:0]        rdata;
  logic [AW-1:0]     raddr;
  logic [AW:0]       diff;

  // result stage
  logic                s1_v;
  lz4d_pkg::stage_ctl_t s1_ctl, r_ctl;
  logic [7:0]          s1_lit;
  logic [AW-1:0]       s1_waddr;
  logic [7:0]          fwd_data;
  logic [7:0]          s1_value;

  logic                out_v;
  logic                acc, s1_adv, hazard;

  function automatic logic exceeds(input logic [CW-1:0] p, input logic [CW-1:0] e,
                                   input logic [LW-1:0] a);
    return (LW'(p) + a) > LW'(e);
  endfunction

  assign s1_adv    = s1_v && (!out_v || dout.ready);
  assign din.ready = !s1_v || s1_adv;
  assign acc       = din.valid && din.ready;
  assign s1_value  = s1_ctl.is_copy ? (s1_ctl.fwd ? fwd_data : rdata) : s1_lit;
  assign diff      = (AW + 1)'(wptr) - (AW + 1)'(match_dist);
  assign raddr     = diff[AW] ? AW'(diff + WIN_EXT) : diff[AW-1:0];
  assign hazard    = s1_adv && s1_ctl.write && (s1_waddr == raddr);

  always_comb begin
    logic [LW-1:0]     sum;
    logic              finish;
    logic              put;
    lz4d_pkg::status_t err;
    lz4d_pkg::status_t st;
    logic [7:0]        b;
    logic              last;

    phase_next           = phase;
    match_nibble_next    = match_nibble;
    lit_left_next        = lit_left;
    match_left_next      = match_left;
    match_dist_next      = match_dist;
    produced_next        = produced;
    expected_next        = expected;
    error_code_next      = error_code;
    ends_after_copy_next = ends_after_copy;
    wptr_next            = wptr;
    b      = din.data_byte;
    last   = din.last_byte;
    finish = 1'b0;
    put    = 1'b0;
    err    = lz4d_pkg::ST_OK;
    st     = error_code;
    sum    = '0;
    r_ctl  = '0;

    if (din.func == lz4d_pkg::FN_TICK) begin
      if (phase == lz4d_pkg::PH_COPY) begin
        put             = 1'b1;
        r_ctl.is_copy   = 1'b1;
        match_left_next = match_left - CW'(1);
        if (match_left_next == '0) begin
          if (ends_after_copy) finish = 1'b1;
          else phase_next = lz4d_pkg::PH_TOKEN;
        end
      end
    end else if (phase == lz4d_pkg::PH_COPY) begin
      st = lz4d_pkg::ST_REJECT;
    end else if (error_code != lz4d_pkg::ST_OK) begin
      if (last) begin
        r_ctl.block_done     = 1'b1;
        phase_next           = lz4d_pkg::PH_IDLE;
        error_code_next      = lz4d_pkg::ST_OK;
        ends_after_copy_next = 1'b0;
      end
    end else begin
      case (phase)
        lz4d_pkg::PH_IDLE, lz4d_pkg::PH_TOKEN: begin
          if (phase == lz4d_pkg::PH_IDLE) begin
            expected_next = (32'(din.block_size) > 32'(MAX_BLOCK_BYTES)) ?
                            CW'(MAX_BLOCK_BYTES) : CW'(din.block_size);
            produced_next = '0;
            wptr_next     = '0;
          end
          lit_left_next     = CW'(b[7:4]);
          match_nibble_next = b[3:0];
          if (exceeds(produced_next, expected_next, LW'(b[7:4])))
            err = lz4d_pkg::ST_OVER;
          else if (b[7:4] == lz4d_pkg::NIBBLE_EXT) phase_next = lz4d_pkg::PH_LITLEN;
          else if (b[7:4] != 4'd0) phase_next = lz4d_pkg::PH_LIT;
          else if (last) finish = 1'b1;
          else phase_next = lz4d_pkg::PH_OFFLO;
          if (err == lz4d_pkg::ST_OK && !finish && last) err = lz4d_pkg::ST_TRUNC;
        end
        lz4d_pkg::PH_LITLEN: begin
          sum           = LW'(lit_left) + LW'(b);
          lit_left_next = CW'(sum);
          if (exceeds(produced, expected, sum)) err = lz4d_pkg::ST_OVER;
          else if (last) err = lz4d_pkg::ST_TRUNC;
          else if (b != lz4d_pkg::BYTE_EXT) phase_next = lz4d_pkg::PH_LIT;
        end
        lz4d_pkg::PH_LIT: begin
          put           = 1'b1;
          lit_left_next = lit_left - CW'(1);
          if (lit_left_next == '0) begin
            if (last) finish = 1'b1;
            else phase_next = lz4d_pkg::PH_OFFLO;
          end else if (last) begin
            err = lz4d_pkg::ST_TRUNC;
          end
        end
        lz4d_pkg::PH_OFFLO: begin
          match_dist_next = {8'd0, b};
          if (last) err = lz4d_pkg::ST_TRUNC;
          else phase_next = lz4d_pkg::PH_OFFHI;
        end
        lz4d_pkg::PH_OFFHI: begin
          match_dist_next = {b, match_dist[7:0]};
          match_left_next = CW'(match_nibble) + CW'(lz4d_pkg::MIN_MATCH);
          if (match_dist_next == 16'd0 || LW'(match_dist_next) > LW'(produced) ||
              32'(match_dist_next) > 32'(WINDOW_BYTES))
            err = lz4d_pkg::ST_OFFSET;
          else if (exceeds(produced, expected, LW'(match_left_next)))
            err = lz4d_pkg::ST_OVER;
          else if (match_nibble == lz4d_pkg::NIBBLE_EXT) begin
            if (last) err = lz4d_pkg::ST_TRUNC;
            else phase_next = lz4d_pkg::PH_MLEN;
          end else begin
            phase_next           = lz4d_pkg::PH_COPY;
            ends_after_copy_next = last;
          end
        end
        lz4d_pkg::PH_MLEN: begin
          sum             = LW'(match_left) + LW'(b);
          match_left_next = CW'(sum);
          if (exceeds(produced, expected, sum)) err = lz4d_pkg::ST_OVER;
          else if (b != lz4d_pkg::BYTE_EXT) begin
            phase_next           = lz4d_pkg::PH_COPY;
            ends_after_copy_next = last;
          end else if (last) begin
            err = lz4d_pkg::ST_TRUNC;
          end
        end
        default: begin
        end
      endcase
      st = err;
      if (err != lz4d_pkg::ST_OK) begin
        if (last) begin
          r_ctl.block_done     = 1'b1;
          phase_next           = lz4d_pkg::PH_IDLE;
          error_code_next      = lz4d_pkg::ST_OK;
          ends_after_copy_next = 1'b0;
        end else begin
          error_code_next      = err;
          phase_next           = lz4d_pkg::PH_TOKEN;
          ends_after_copy_next = 1'b0;
        end
      end
    end

    if (put) begin
      produced_next = produced_next + CW'(1);
      wptr_next     = (wptr == WIN_LAST) ? '0 : wptr + AW'(1);
    end
    if (finish) begin
      st = (produced_next == expected_next) ? lz4d_pkg::ST_OK : lz4d_pkg::ST_MISMATCH;
      r_ctl.block_done     = 1'b1;
      phase_next           = lz4d_pkg::PH_IDLE;
      error_code_next      = lz4d_pkg::ST_OK;
      ends_after_copy_next = 1'b0;
    end

    r_ctl.write        = put;
    r_ctl.byte_valid   = put && (st == lz4d_pkg::ST_OK);
    r_ctl.status       = st;
    r_ctl.copy_pending = (phase_next == lz4d_pkg::PH_COPY);
    r_ctl.fwd          = r_ctl.is_copy && hazard;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lz4d_pkg::PH_IDLE;
      match_nibble    <= '0;
      lit_left        <= '0;
      match_left      <= '0;
      match_dist      <= '0;
      produced        <= '0;
      expected        <= '0;
      error_code      <= lz4d_pkg::ST_OK;
      ends_after_copy <= 1'b0;
      wptr            <= '0;
    end else if (acc) begin
      phase           <= phase_next;
      match_nibble    <= match_nibble_next;
      lit_left        <= lit_left_next;
      match_left      <= match_left_next;
      match_dist      <= match_dist_next;
      produced        <= produced_next;
      expected        <= expected_next;
      error_code      <= error_code_next;
      ends_after_copy <= ends_after_copy_next;
      wptr            <= wptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) rdata <= hist[raddr];
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ctl.write) hist[s1_waddr] <= s1_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v   <= 1'b0;
      s1_ctl <= '0;
    end else begin
      if (acc) begin
        s1_v   <= 1'b1;
        s1_ctl <= r_ctl;
      end else if (s1_adv) begin
        s1_v   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_lit   <= din.data_byte;
      s1_waddr <= wptr;
      fwd_data <= s1_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s1_adv) begin
      out_v <= 1'b1;
    end else if (dout.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dout.out_byte     <= s1_ctl.byte_valid ? s1_value : 8'd0;
      dout.byte_valid   <= s1_ctl.byte_valid;
      dout.copy_pending <= s1_ctl.copy_pending;
      dout.block_done   <= s1_ctl.block_done;
      dout.status       <= s1_ctl.status;
    end
  end

  assign dout.valid = out_v;

endmodule

[test/lz4_block_decoder_checker.sv]
// Checker for the LZ4 block decoder: predicts every decoded result and compares it at dout.
module lz4_block_decoder_checker #(
  parameter int unsigned WINDOW_BYTES    = 65536,
  parameter int unsigned MAX_BLOCK_BYTES = 4194304
) (
  input  logic clk,
  input  logic rst,
  lz4d_in_if   din,
  lz4d_out_if  dout,
  output int   mismatches,
  output int   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic              copy_pending;
    logic              block_done;
    lz4d_pkg::status_t status;
  } dec_result_t;

  lz4d_pkg::phase_t  ph;
  logic [3:0]        m_nib;
  logic [22:0]       lit_left;
  logic [22:0]       match_left;
  logic [15:0]       m_dist;
  logic [22:0]       produced;
  logic [22:0]       exp_size;
  lz4d_pkg::status_t err_code;
  logic              ends_after;
  logic [7:0]        hist [WINDOW_BYTES];

  dec_result_t decoded_q [$];
  dec_result_t want;
  int          mismatch_cnt = 0;

  assign mismatches = mismatch_cnt;

  function automatic logic exceeds(input logic [22:0] add);
    return ({1'b0, produced} + {1'b0, add}) > {1'b0, exp_size};
  endfunction

  task automatic go_idle();
    ph = lz4d_pkg::PH_IDLE;
    err_code = lz4d_pkg::ST_OK;
    ends_after = 1'b0;
  endtask

  task automatic reset_decoder();
    m_nib = '0;
    lit_left = '0;
    match_left = '0;
    m_dist = '0;
    produced = '0;
    exp_size = '0;
    go_idle();
  endtask

  task automatic put_byte(input logic [7:0] v);
    hist[produced % WINDOW_BYTES] = v;
    produced = produced + 1'b1;
  endtask

  task automatic decode_item(input lz4d_pkg::func_t f, input logic [7:0] b,
                             input logic last, input logic [22:0] bs,
                             output dec_result_t r);
    logic [7:0]        ob;
    logic              bv;
    logic              done;
    logic              finish;
    lz4d_pkg::status_t st;
    lz4d_pkg::status_t err;
    int unsigned       src;
    ob = '0;
    bv = 1'b0;
    done = 1'b0;
    finish = 1'b0;
    st = err_code;
    err = lz4d_pkg::ST_OK;
    if (f == lz4d_pkg::FN_TICK) begin
      if (ph == lz4d_pkg::PH_COPY) begin
        src = (32'(produced) - 32'(m_dist)) % WINDOW_BYTES;
        ob = hist[src];
        put_byte(ob);
        bv = 1'b1;
        match_left = match_left - 1'b1;
        if (match_left == 0) begin
          if (ends_after) finish = 1'b1;
          else ph = lz4d_pkg::PH_TOKEN;
        end
      end
    end else if (ph == lz4d_pkg::PH_COPY) begin
      st = lz4d_pkg::ST_REJECT;
    end else if (err_code != lz4d_pkg::ST_OK) begin
      // draining after an error until the last byte
      if (last) begin
        done = 1'b1;
        go_idle();
      end
    end else begin
      case (ph)
        lz4d_pkg::PH_IDLE, lz4d_pkg::PH_TOKEN: begin
          if (ph == lz4d_pkg::PH_IDLE) begin
            exp_size = (bs > MAX_BLOCK_BYTES) ? 23'(MAX_BLOCK_BYTES) : bs;
            produced = '0;
          end
          lit_left = 23'(b[7:4]);
          m_nib = b[3:0];
          if (exceeds(lit_left)) err = lz4d_pkg::ST_OVER;
          else if (lit_left == 23'(lz4d_pkg::NIBBLE_EXT)) ph = lz4d_pkg::PH_LITLEN;
          else if (lit_left > 0) ph = lz4d_pkg::PH_LIT;
          else if (last) finish = 1'b1;
          else ph = lz4d_pkg::PH_OFFLO;
          if (err == lz4d_pkg::ST_OK && !finish && last) err = lz4d_pkg::ST_TRUNC;
        end
        lz4d_pkg::PH_LITLEN: begin
          lit_left = lit_left + 23'(b);
          if (exceeds(lit_left)) err = lz4d_pkg::ST_OVER;
          else if (last) err = lz4d_pkg::ST_TRUNC;
          else if (b != lz4d_pkg::BYTE_EXT) ph = lz4d_pkg::PH_LIT;
        end
        lz4d_pkg::PH_LIT: begin
          ob = b;
          bv = 1'b1;
          put_byte(b);
          lit_left = lit_left - 1'b1;
          if (lit_left == 0) begin
            if (last) finish = 1'b1;
            else ph = lz4d_pkg::PH_OFFLO;
          end else if (last) begin
            err = lz4d_pkg::ST_TRUNC;
          end
        end
        lz4d_pkg::PH_OFFLO: begin
          m_dist = {8'h00, b};
          if (last) err = lz4d_pkg::ST_TRUNC;
          else ph = lz4d_pkg::PH_OFFHI;
        end
        lz4d_pkg::PH_OFFHI: begin
          m_dist[15:8] = b;
          match_left = 23'(m_nib) + 23'(lz4d_pkg::MIN_MATCH);
          if (m_dist == 0 || 23'(m_dist) > produced || 32'(m_dist) > WINDOW_BYTES) begin
            err = lz4d_pkg::ST_OFFSET;
          end else if (exceeds(match_left)) begin
            err = lz4d_pkg::ST_OVER;
          end else if (m_nib == lz4d_pkg::NIBBLE_EXT) begin
            if (last) err = lz4d_pkg::ST_TRUNC;
            else ph = lz4d_pkg::PH_MLEN;
          end else begin
            ph = lz4d_pkg::PH_COPY;
            ends_after = last;
          end
        end
        default: begin
          match_left = match_left + 23'(b);
          if (exceeds(match_left)) begin
            err = lz4d_pkg::ST_OVER;
          end else if (b != lz4d_pkg::BYTE_EXT) begin
            ph = lz4d_pkg::PH_COPY;
            ends_after = last;
          end else if (last) begin
            err = lz4d_pkg::ST_TRUNC;
          end
        end
      endcase
      st = lz4d_pkg::ST_OK;
      if (err != lz4d_pkg::ST_OK) begin
        st = err;
        if (last) begin
          done = 1'b1;
          go_idle();
        end else begin
          err_code = err;
          ph = lz4d_pkg::PH_TOKEN;
          ends_after = 1'b0;
        end
      end
    end
    if (finish) begin
      st = (produced == exp_size) ? lz4d_pkg::ST_OK : lz4d_pkg::ST_MISMATCH;
      done = 1'b1;
      go_idle();
    end
    if (st != lz4d_pkg::ST_OK) begin
      bv = 1'b0;
      ob = '0;
    end
    r.out_byte = ob;
    r.byte_valid = bv;
    r.copy_pending = (ph == lz4d_pkg::PH_COPY);
    r.block_done = done;
    r.status = st;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_decoder();
      decoded_q.delete();
    end else begin
      if (din.valid && din.ready) begin
        decode_item(din.func, din.data_byte, din.last_byte, din.block_size, want);
        decoded_q.push_back(want);
      end
      if (dout.valid && dout.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result with no item waiting: out_byte %0d status %0d",
                 dout.out_byte, dout.status);
          mismatch_cnt++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte", want.out_byte, dout.out_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(dout.byte_valid));
          check_field("copy_pending", 8'(want.copy_pending), 8'(dout.copy_pending));
          check_field("block_done", 8'(want.block_done), 8'(dout.block_done));
          check_field("status", 8'(want.status), 8'(dout.status));
        end
      end
    end
    results_owed <= decoded_q.size();
  end

endmodule

[test/tb_lz4_block_decoder_top.sv]
// Testbench top: builds LZ4 block streams, drives the decoder and reports the verdict.
module tb_lz4_block_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    lz4d_pkg::func_t func;
    logic [7:0]      data;
    logic            last;
    logic [22:0]     bsize;
  } din_item_t;

  logic clk = 1'b0;
  logic rst;

  lz4d_in_if  din_if ();
  lz4d_out_if dout_if ();

  int mismatch_cnt;
  int results_owed;

  din_item_t blk_q [$];
  int        data_idx [$];
  int        made;
  int        burst_left;
  int        quiet_left;
  int        items_sent;
  int        blocks;
  int        stall_cnt = 0;
  int        stall_mode = 0;

  lz4_block_decoder_top DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  lz4_block_decoder_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .din          (din_if),
    .dout         (dout_if),
    .mismatches   (mismatch_cnt),
    .results_owed (results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 200 == 0) stall_mode <= $urandom_range(0, 4);
    case (stall_mode)
      0: dout_if.ready <= 1'b1;
      1: dout_if.ready <= ($urandom_range(0, 3) != 0);
      2: dout_if.ready <= 1'($urandom_range(0, 1));
      3: dout_if.ready <= ((stall_cnt % 9) < 5);
      default: dout_if.ready <= ((stall_cnt % 40) >= 18);
    endcase
  end

  task automatic send_one(input din_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (quiet_left > 0) ? 0 : $urandom_range(0, 6);
      if (quiet_left > 0) quiet_left--;
      else if ($urandom_range(0, 15) == 0) quiet_left = $urandom_range(5, 20);
      if (gap > 0) begin
        din_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    din_if.valid      <= 1'b1;
    din_if.func       <= it.func;
    din_if.data_byte  <= it.data;
    din_if.last_byte  <= it.last;
    din_if.block_size <= it.bsize;
    @(posedge clk);
    while (!din_if.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drain();
    din_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic start_block();
    blk_q.delete();
    data_idx.delete();
    made = 0;
  endtask

  task automatic add_raw(input lz4d_pkg::func_t f, input logic [7:0] b, input logic l);
    blk_q.push_back('{func: f, data: b, last: l, bsize: 23'($urandom)});
  endtask

  task automatic add_tick();
    add_raw(lz4d_pkg::FN_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic add_data(input logic [7:0] b);
    data_idx.push_back(blk_q.size());
    add_raw(lz4d_pkg::FN_DATA, b, 1'b0);
  endtask

  task automatic add_len(input int rem);
    while (rem >= 255) begin
      add_data(lz4d_pkg::BYTE_EXT);
      rem -= 255;
    end
    add_data(8'(rem));
  endtask

  // one full sequence: token, literals, offset, match length, then the copy ticks
  task automatic add_seq(input int lits, input int mlen, input int off);
    logic [3:0] lnib;
    logic [3:0] mnib;
    lnib = (lits >= 15) ? lz4d_pkg::NIBBLE_EXT : 4'(lits);
    mnib = (mlen - 4 >= 15) ? lz4d_pkg::NIBBLE_EXT : 4'(mlen - 4);
    add_data({lnib, mnib});
    if (lits >= 15) add_len(lits - 15);
    repeat (lits) add_data(8'($urandom));
    made += lits;
    add_data(8'(off));
    add_data(8'(off >> 8));
    if (mlen - 4 >= 15) add_len(mlen - 19);
    for (int k = 0; k < mlen; k++) begin
      if (k == mlen / 2 && $urandom_range(0, 19) == 0)
        add_raw(lz4d_pkg::FN_DATA, 8'($urandom), 1'b0);
      add_tick();
    end
    made += mlen;
  endtask

  task automatic add_tail(input int lits);
    add_data({(lits >= 15) ? lz4d_pkg::NIBBLE_EXT : 4'(lits), 4'($urandom)});
    if (lits >= 15) add_len(lits - 15);
    repeat (lits) add_data(8'($urandom));
    made += lits;
  endtask

  // last on data item number cut (or the final one), drop what follows its tick run
  task automatic emit_block(input logic [22:0] bsize, input int cut);
    int stop;
    if (cut < 0) cut = data_idx.size() - 1;
    blk_q[data_idx[0]].bsize = bsize;
    blk_q[data_idx[cut]].last = 1'b1;
    stop = (cut + 1 < data_idx.size()) ? data_idx[cut + 1] : blk_q.size();
    for (int i = 0; i < stop; i++) send_one(blk_q[i]);
  endtask

  task automatic random_block();
    int kind;
    int n_seq;
    int lits;
    int mlen;
    int off;
    int reach;
    int bad_at;
    int bsize;
    int cut;
    int r;
    kind = $urandom_range(0, 99);
    start_block();
    if ($urandom_range(0, 19) == 0) add_tick();
    if (kind >= 90) begin
      n_seq = $urandom_range(1, 12);
      add_data(8'($urandom));
      repeat (n_seq - 1) begin
        if ($urandom_range(0, 4) == 0) add_tick();
        else add_data(8'($urandom));
      end
      bsize = $urandom_range(0, 1) ? $urandom_range(0, 64) : $urandom_range(0, 23'h7FFFFF);
      emit_block(23'(bsize), -1);
    end else begin
      n_seq = $urandom_range(1, 4);
      bad_at = $urandom_range(0, n_seq - 1);
      for (int i = 0; i < n_seq; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) lits = $urandom_range(270, 300);
        else if (r < 15) lits = $urandom_range(15, 40);
        else lits = $urandom_range((i == 0) ? 1 : 0, 14);
        r = $urandom_range(0, 99);
        if (r < 3) mlen = $urandom_range(274, 290);
        else if (r < 15) mlen = $urandom_range(19, 40);
        else mlen = $urandom_range(4, 18);
        reach = (made + lits > 65535) ? 65535 : made + lits;
        if (kind >= 84 && i == bad_at)
          off = ($urandom_range(0, 1) && made + lits + 8 <= 65535) ?
                made + lits + $urandom_range(1, 8) : 0;
        else
          off = $urandom_range(1, reach);
        add_seq(lits, mlen, off);
      end
      if ($urandom_range(0, 9) < 7) add_tail($urandom_range(0, 8));
      bsize = made;
      cut = -1;
      if (kind >= 60 && kind < 68) begin
        case ($urandom_range(0, 2))
          0: bsize = made + $urandom_range(1, 4);
          1: bsize = $urandom_range(4194305, 23'h7FFFFF);
          default: bsize = (made > 0) ? made - 1 : 1;
        endcase
      end else if (kind >= 68 && kind < 76) begin
        bsize = (made > 0) ? $urandom_range(0, made - 1) : 0;
      end else if (kind >= 76 && kind < 84 && data_idx.size() > 1) begin
        cut = $urandom_range(0, data_idx.size() - 2);
      end
      emit_block(23'(bsize), cut);
    end
  endtask

  initial begin
    rst                <= 1'b1;
    din_if.valid       <= 1'b0;
    din_if.func        <= lz4d_pkg::FN_DATA;
    din_if.data_byte   <= '0;
    din_if.last_byte   <= 1'b0;
    din_if.block_size  <= '0;
    burst_left = 0;
    quiet_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty block
    start_block();
    add_data(8'h00);
    emit_block(23'd0, -1);
    // clamped size, one literal
    start_block();
    add_data(8'h10);
    add_data(8'hFF);
    emit_block(23'h7FFFFF, -1);
    // idle tick, block ending in a match, byte sent during the copy
    start_block();
    add_raw(lz4d_pkg::FN_TICK, 8'hFF, 1'b1);
    add_data(8'h10);
    add_data(8'h00);
    add_data(8'h01);
    add_data(8'h00);
    add_tick();
    add_tick();
    add_raw(lz4d_pkg::FN_DATA, 8'h5A, 1'b0);
    add_tick();
    add_tick();
    emit_block(23'd5, -1);
    // overflow on the token, then drain
    start_block();
    add_data(8'hF0);
    add_data(8'hAA);
    emit_block(23'd3, -1);
    // zero offset
    start_block();
    add_data(8'h10);
    add_data(8'h33);
    add_data(8'h00);
    add_data(8'h00);
    add_data(8'h00);
    emit_block(23'd5, -1);
    // truncated literals
    start_block();
    add_data(8'h20);
    add_data(8'hC3);
    emit_block(23'd2, -1);
    wait_drain();

    items_sent = 0;
    blocks = 0;
    while (items_sent < 950) begin
      random_block();
      blocks++;
      if (blocks % 25 == 0) wait_drain();
    end

    wait_drain();
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0) $display("tb_lz4_block_decoder_top: clean");
    else $display("tb_lz4_block_decoder_top: errors");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_lz4_block_decoder_top: errors");
    $finish;
  end

endmodule
